### rtl/ssp_pkg.sv
// Shared types, constants and the CRC-16 byte update for the servo status packet parser.
// No dependencies; imported by ssp_parser, ssp_result_buf and the top level.
package ssp_pkg;

  localparam logic [7:0]  HdrByte0     = 8'hFF;
  localparam logic [7:0]  HdrByte2     = 8'hFD;
  localparam logic [7:0]  RsvByte      = 8'h00;
  localparam logic [7:0]  StatusInst   = 8'h55;
  localparam logic [15:0] CrcPoly      = 16'h8005;
  localparam logic [15:0] MinLength    = 16'd4;
  localparam logic [15:0] MaxLengthRst = 16'd505;

  typedef enum logic [3:0] {
    PhH0    = 4'd0,
    PhH1    = 4'd1,
    PhH2    = 4'd2,
    PhRsv   = 4'd3,
    PhId    = 4'd4,
    PhLenL  = 4'd5,
    PhLenH  = 4'd6,
    PhInst  = 4'd7,
    PhErr   = 4'd8,
    PhParam = 4'd9,
    PhCrcL  = 4'd10,
    PhCrcH  = 4'd11
  } ssp_phase_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StCrcBad   = 2'd1,
    StFrameBad = 2'd2,
    StLenBad   = 2'd3
  } ssp_status_e;

  localparam logic KindParam = 1'b0;
  localparam logic KindEnd   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  param_byte;
    logic [15:0] param_index;
    logic [7:0]  pkt_id;
    logic [7:0]  servo_error;
    logic [15:0] param_count;
    logic [1:0]  status;
  } ssp_result_t;

  // Push toward the result buffer.
  typedef struct packed {
    logic push;
  } ssp_push_t;

  // MSB-first CRC-16 update over one byte, no reflection.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CrcPoly;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // CRC after FF FF FD, starting from zero.
  localparam logic [15:0] CrcHeader =
    crc_byte(crc_byte(crc_byte(16'h0000, HdrByte0), HdrByte0), HdrByte2);

endpackage

### rtl/ssp_parser.sv
// Input byte register and per-byte packet state machine with the running CRC.
// Depends on ssp_pkg.
module ssp_parser import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic [15:0] max_length_i,
  input  logic        buf_space_i,
  output ssp_push_t   push_o,
  output ssp_result_t result_o
);

  logic        byte_vld_q;
  logic [7:0]  byte_q;
  logic        fire;

  ssp_phase_e  phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  err_q, err_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] pcnt_q, pcnt_d;
  logic        bad_q, bad_d;

  logic [15:0] crc_upd;
  logic [15:0] len_w;
  logic        len_bad;
  logic        res_vld;

  assign fire       = byte_vld_q && buf_space_i;
  assign in_ready_o = !byte_vld_q || fire;
  assign crc_upd    = crc_byte(crc_q, byte_q);
  assign len_w      = {byte_q, len_lo_q};
  assign len_bad    = (len_w < MinLength) || (len_w > max_length_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    crc_d    = crc_q;
    left_d   = left_q;
    len_lo_d = len_lo_q;
    id_d     = id_q;
    err_d    = err_q;
    crc_lo_d = crc_lo_q;
    pcnt_d   = pcnt_q;
    bad_d    = bad_q;
    unique case (phase_q)
      PhH0: begin
        if (byte_q == HdrByte0) phase_d = PhH1;
      end
      PhH1: begin
        phase_d = (byte_q == HdrByte0) ? PhH2 : PhH0;
      end
      PhH2: begin
        if (byte_q == HdrByte2) begin
          crc_d   = CrcHeader;
          bad_d   = 1'b0;
          pcnt_d  = '0;
          phase_d = PhRsv;
        end else if (byte_q != HdrByte0) begin
          phase_d = PhH0;
        end
      end
      PhRsv: begin
        crc_d   = crc_upd;
        bad_d   = bad_q || (byte_q != RsvByte);
        phase_d = PhId;
      end
      PhId: begin
        crc_d   = crc_upd;
        id_d    = byte_q;
        phase_d = PhLenL;
      end
      PhLenL: begin
        crc_d    = crc_upd;
        len_lo_d = byte_q;
        phase_d  = PhLenH;
      end
      PhLenH: begin
        crc_d = crc_upd;
        if (len_bad) begin
          phase_d = PhH0;
        end else begin
          left_d  = len_w - MinLength;
          phase_d = PhInst;
        end
      end
      PhInst: begin
        crc_d   = crc_upd;
        bad_d   = bad_q || (byte_q != StatusInst);
        phase_d = PhErr;
      end
      PhErr: begin
        crc_d   = crc_upd;
        err_d   = byte_q;
        phase_d = (left_q == '0) ? PhCrcL : PhParam;
      end
      PhParam: begin
        crc_d   = crc_upd;
        pcnt_d  = pcnt_q + 16'd1;
        left_d  = left_q - 16'd1;
        if (left_q == 16'd1) phase_d = PhCrcL;
      end
      PhCrcL: begin
        crc_lo_d = byte_q;
        phase_d  = PhCrcH;
      end
      PhCrcH: begin
        phase_d = PhH0;
      end
      default: begin
        phase_d = PhH0;
      end
    endcase
  end

  // Result for the byte in flight.
  always_comb begin
    res_vld  = 1'b0;
    result_o = '0;
    unique case (phase_q)
      PhLenH: begin
        if (len_bad) begin
          res_vld         = 1'b1;
          result_o.kind   = KindEnd;
          result_o.pkt_id = id_q;
          result_o.status = StLenBad;
        end
      end
      PhParam: begin
        res_vld              = 1'b1;
        result_o.kind        = KindParam;
        result_o.param_byte  = byte_q;
        result_o.param_index = pcnt_q;
      end
      PhCrcH: begin
        res_vld              = 1'b1;
        result_o.kind        = KindEnd;
        result_o.pkt_id      = id_q;
        result_o.servo_error = err_q;
        result_o.param_count = pcnt_q;
        if (bad_q)                           result_o.status = StFrameBad;
        else if ({byte_q, crc_lo_q} != crc_q) result_o.status = StCrcBad;
        else                                 result_o.status = StOk;
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
    push_o.push = fire && res_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhH0;
      crc_q    <= '0;
      left_q   <= '0;
      len_lo_q <= '0;
      id_q     <= '0;
      err_q    <= '0;
      crc_lo_q <= '0;
      pcnt_q   <= '0;
      bad_q    <= 1'b0;
    end else if (fire) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      left_q   <= left_d;
      len_lo_q <= len_lo_d;
      id_q     <= id_d;
      err_q    <= err_d;
      crc_lo_q <= crc_lo_d;
      pcnt_q   <= pcnt_d;
      bad_q    <= bad_d;
    end
  end

  // A parameter byte is only ever pushed while bytes remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.push && result_o.kind == KindParam) |-> (left_q != '0))
    else $error("parameter result with no bytes left");

  // A packet end always sends the parser back to hunting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.push && result_o.kind == KindEnd) |=> (phase_q == PhH0))
    else $error("end result did not restart header hunt");

  // Parameter index tracks the running count after each parameter byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.push && result_o.kind == KindParam) |=> (pcnt_q == $past(result_o.param_index) + 16'd1))
    else $error("parameter counter out of step");

endmodule

### rtl/ssp_result_buf.sv
// Two-entry registered result buffer between the parser and the output stream.
// Depends on ssp_pkg.
module ssp_result_buf import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ssp_push_t   push_i,
  input  ssp_result_t data_i,
  output logic        space_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ssp_result_t out_data_o
);

  logic [1:0]  count_q, count_d;
  ssp_result_t head_q, tail_q;
  logic        pop;

  assign pop         = (count_q != 2'd0) && out_ready_i;
  assign space_o     = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = head_q;

  always_comb begin
    count_d = count_q;
    case ({push_i.push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold results; advance tail to head on a pop.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (count_q == 2'd2) begin
        head_q <= tail_q;
        if (push_i.push) tail_q <= data_i;
      end else if (push_i.push) begin
        head_q <= data_i;
      end
    end else if (push_i.push) begin
      if (count_q == 2'd0) head_q <= data_i;
      else                 tail_q <= data_i;
    end
  end

endmodule

### rtl/servo_status_packet_parser_top.sv
// Top level of the servo status packet parser: byte stream in, parameter and end results out.
// Depends on ssp_pkg, ssp_parser and ssp_result_buf.
//
// Takes one received bus byte per request on the slave stream and parses status packets
// of the form FF FF FD 00 ID LEN_L LEN_H 55 ERR P0..Pn-1 CRC_L CRC_H with LEN = n + 4.
// Each parameter byte is sent as a result with tuser = 0 and its index; the high CRC
// byte gives an end result with tuser = 1 carrying ID, error byte, parameter count and
// status (0 ok, 1 CRC mismatch, 2 bad reserved or instruction byte, 3 bad length).
// A length below 4 or above max_length ends the packet at once on LEN_H with status 3.
// The CRC-16 (poly 0x8005, MSB first, init 0) covers every byte from the first FF to the
// last parameter byte. Throughput is one byte per clock while the output buffer has space: a byte
// sits in the input register while the phase logic and a single-byte CRC update run, and its
// result is written to a two-entry output buffer that feeds the result stream.
// The output buffer decouples backpressure; the input stalls only while both entries are
// full. Write max_length (reset 505) only while no packet bytes are in flight.
module servo_status_packet_parser_top import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: max_length
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Byte input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] param_byte, [23:8] param_index, [31:24] pkt_id, [39:32] servo_error,
  // [55:40] param_count, [57:56] status, [63:58] zero
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser   // [0] kind
);

  logic [15:0] max_length_q;
  logic        buf_space;
  ssp_push_t   push;
  ssp_result_t result;
  ssp_result_t out_res;

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MaxLengthRst;
    end else if (cfg_valid_i) begin
      max_length_q <= cfg_data_i;
    end
  end

  ssp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .max_length_i (max_length_q),
    .buf_space_i  (buf_space),
    .push_o       (push),
    .result_o     (result)
  );

  ssp_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (result),
    .space_o     (buf_space),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  // Pack the result fields, first field lowest.
  assign m_axis_tdata = {6'b0, out_res.status, out_res.param_count, out_res.servo_error,
                         out_res.pkt_id, out_res.param_index, out_res.param_byte};
  assign m_axis_tuser = out_res.kind;

endmodule

### verif/servo_status_packet_parser_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the servo status packet parser: tracks the byte, config and result channels.
// Depends on ssp_pkg; defines ssp_tb_pkg, whose CRC update the stimulus also uses.

package ssp_tb_pkg;
  import ssp_pkg::*;

  // Bit-serial CRC-16, data shifted in MSB first.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ CrcPoly;
    end
    return acc;
  endfunction
endpackage

module servo_status_packet_parser_checker import ssp_pkg::*, ssp_tb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        byte_valid_i,
  input  logic        byte_ready_i,
  input  logic [7:0]  byte_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [63:0] res_data_i,
  input  logic        res_user_i,
  output int          mismatch_count_o,
  output int          awaiting_o
);

  logic [15:0] max_len_q;
  ssp_phase_e  phase_q;
  logic [15:0] crc_q;
  logic [15:0] remaining_q;
  logic [15:0] param_pos_q;
  logic [7:0]  len_lo_q;
  logic [7:0]  id_q;
  logic [7:0]  err_q;
  logic [7:0]  crc_lo_q;
  logic        frame_bad_q;
  ssp_result_t packet_out_q[$];

  task automatic parse_byte(input logic [7:0] b);
    ssp_result_t r;
    logic [15:0] len;
    r = '0;
    case (phase_q)
      PhH0: if (b == HdrByte0) phase_q = PhH1;
      PhH1: phase_q = (b == HdrByte0) ? PhH2 : PhH0;
      PhH2: begin
        if (b == HdrByte2) begin
          crc_q       = crc16_update(crc16_update(crc16_update(16'h0000, HdrByte0), HdrByte0),
                                     HdrByte2);
          frame_bad_q = 1'b0;
          param_pos_q = '0;
          phase_q     = PhRsv;
        end else if (b != HdrByte0) begin
          phase_q = PhH0;
        end
      end
      PhRsv: begin
        crc_q = crc16_update(crc_q, b);
        if (b != RsvByte) frame_bad_q = 1'b1;
        phase_q = PhId;
      end
      PhId: begin
        crc_q   = crc16_update(crc_q, b);
        id_q    = b;
        phase_q = PhLenL;
      end
      PhLenL: begin
        crc_q    = crc16_update(crc_q, b);
        len_lo_q = b;
        phase_q  = PhLenH;
      end
      PhLenH: begin
        crc_q = crc16_update(crc_q, b);
        len   = {b, len_lo_q};
        if (len < MinLength || len > max_len_q) begin
          // out-of-range length closes the packet right here
          r.kind   = KindEnd;
          r.pkt_id = id_q;
          r.status = StLenBad;
          packet_out_q.push_back(r);
          phase_q = PhH0;
        end else begin
          remaining_q = len - MinLength;
          phase_q     = PhInst;
        end
      end
      PhInst: begin
        crc_q = crc16_update(crc_q, b);
        if (b != StatusInst) frame_bad_q = 1'b1;
        phase_q = PhErr;
      end
      PhErr: begin
        crc_q   = crc16_update(crc_q, b);
        err_q   = b;
        phase_q = (remaining_q == 16'd0) ? PhCrcL : PhParam;
      end
      PhParam: begin
        crc_q         = crc16_update(crc_q, b);
        r.kind        = KindParam;
        r.param_byte  = b;
        r.param_index = param_pos_q;
        packet_out_q.push_back(r);
        param_pos_q = param_pos_q + 16'd1;
        remaining_q = remaining_q - 16'd1;
        if (remaining_q == 16'd0) phase_q = PhCrcL;
      end
      PhCrcL: begin
        crc_lo_q = b;
        phase_q  = PhCrcH;
      end
      PhCrcH: begin
        r.kind        = KindEnd;
        r.pkt_id      = id_q;
        r.servo_error = err_q;
        r.param_count = param_pos_q;
        r.status      = frame_bad_q ? StFrameBad :
                        (({b, crc_lo_q} != crc_q) ? StCrcBad : StOk);
        packet_out_q.push_back(r);
        phase_q = PhH0;
      end
      default: phase_q = PhH0;
    endcase
  endtask

  function automatic int field_bad(input string name, input logic [15:0] want,
                                   input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_result(input logic [63:0] d, input logic user);
    ssp_result_t want;
    if (packet_out_q.size() == 0) begin
      $error("result with nothing pending: tuser %0b tdata %h", user, d);
      mismatch_count_o++;
      return;
    end
    want = packet_out_q.pop_front();
    mismatch_count_o += field_bad("kind", 16'(want.kind), 16'(user));
    mismatch_count_o += field_bad("param_byte", 16'(want.param_byte), 16'(d[7:0]));
    mismatch_count_o += field_bad("param_index", want.param_index, d[23:8]);
    mismatch_count_o += field_bad("pkt_id", 16'(want.pkt_id), 16'(d[31:24]));
    mismatch_count_o += field_bad("servo_error", 16'(want.servo_error), 16'(d[39:32]));
    mismatch_count_o += field_bad("param_count", want.param_count, d[55:40]);
    mismatch_count_o += field_bad("status", 16'(want.status), 16'(d[57:56]));
    mismatch_count_o += field_bad("tdata pad", 16'h0000, 16'(d[63:58]));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q        = MaxLengthRst;
      phase_q          = PhH0;
      crc_q            = '0;
      remaining_q      = '0;
      param_pos_q      = '0;
      len_lo_q         = '0;
      id_q             = '0;
      err_q            = '0;
      crc_lo_q         = '0;
      frame_bad_q      = 1'b0;
      mismatch_count_o = 0;
      packet_out_q.delete();
      awaiting_o <= 0;
    end else begin
      // a result leaving at this edge belongs to an earlier request
      if (res_valid_i && res_ready_i) check_result(res_data_i, res_user_i);
      if (cfg_valid_i && cfg_ready_i) max_len_q = cfg_data_i;
      if (byte_valid_i && byte_ready_i) parse_byte(byte_data_i);
      awaiting_o <= packet_out_q.size();
    end
  end

endmodule

### verif/servo_status_packet_parser_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for servo_status_packet_parser_top: byte traffic, max_length writes, backpressure.
// Depends on ssp_pkg, ssp_tb_pkg and servo_status_packet_parser_checker for the verdict.
module servo_status_packet_parser_top_tb;
  import ssp_pkg::*;
  import ssp_tb_pkg::*;

  // Generous bound: roughly 1k bytes, each at worst a sender gap plus a long output stall.
  localparam int CycleLimit   = 400000;
  // Bytes of packet traffic to send in total, split over the max_length settings.
  localparam int ByteTarget   = 700;
  localparam int NumSettings  = 5;
  // Let a byte that makes no result clear the input register before touching max_length.
  localparam int SettleCycles = 8;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  int          fail_count;
  int          awaiting;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned packet_bytes = 0;
  logic [15:0] cur_max      = MaxLengthRst;

  servo_status_packet_parser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  servo_status_packet_parser_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .byte_valid_i     (s_axis_tvalid),
    .byte_ready_i     (s_axis_tready),
    .byte_data_i      (s_axis_tdata),
    .res_valid_i      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_data_i       (m_axis_tdata),
    .res_user_i       (m_axis_tuser),
    .mismatch_count_o (fail_count),
    .awaiting_o       (awaiting)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on either stream.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: switch between random stall patterns so that backpressure
  // lands on parameter results and end results alike, with fully open stretches too.
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((mode_left % 16) < 5);  // long periodic stall
    endcase
  end

  // Present one byte and hold it until the request is taken. Bursts of random length
  // are separated by random gaps; a zero gap joins two bursts into one long stretch.
  // Called and returning at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every predicted result has left the block.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (awaiting != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    wait_idle();
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_max = v;
  endtask

  // Build one status packet and send its first cut_at bytes. A length outside the
  // accepted range stops after LEN_H, where the block ends the packet anyway.
  task automatic send_packet(input logic [7:0] id, input logic [15:0] len,
                             input logic [7:0] err, input logic bad_rsv,
                             input logic bad_inst, input logic bad_crc,
                             input int unsigned cut_at);
    logic [7:0]  pkt[$];
    logic [15:0] crc;
    logic [7:0]  rsv;
    logic [7:0]  inst;
    rsv  = bad_rsv ? 8'($urandom_range(1, 255)) : RsvByte;
    inst = StatusInst;
    if (bad_inst) begin
      inst = 8'($urandom_range(0, 255));
      if (inst == StatusInst) inst = ~StatusInst;
    end
    pkt = '{HdrByte0, HdrByte0, HdrByte2, rsv, id, len[7:0], len[15:8]};
    if (len >= MinLength && len <= cur_max) begin
      pkt.push_back(inst);
      pkt.push_back(err);
      for (int i = 0; i < int'(len) - 4; i++) pkt.push_back(8'($urandom_range(0, 255)));
      crc = '0;
      foreach (pkt[i]) crc = crc16_update(crc, pkt[i]);
      if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
      pkt.push_back(crc[7:0]);
      pkt.push_back(crc[15:8]);
    end
    foreach (pkt[i]) begin
      if (i < cut_at) begin
        send_byte(pkt[i]);
        packet_bytes++;
      end
    end
  endtask

  // One random step: mostly well-formed packets with random faults, some line noise,
  // broken header fragments and, where lengths stay small, truncated packets.
  task automatic send_random_traffic();
    int unsigned sel;
    int unsigned npar;
    logic [15:0] len;
    logic [7:0]  b;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      // noise; keep FD out when a stray header could swallow a huge length
      repeat ($urandom_range(1, 6)) begin
        b = ($urandom_range(0, 2) == 0) ? HdrByte0 : 8'($urandom_range(0, 255));
        if (cur_max > 16'd600 && b == HdrByte2) b = RsvByte;
        send_byte(b);
      end
      return;
    end
    if (sel < 14) wait_idle();
    // header hunting: extra FF before the packet, or a fragment that restarts the hunt
    case ($urandom_range(0, 9))
      0, 1: repeat ($urandom_range(1, 2)) send_byte(HdrByte0);
      2: begin
        send_byte(HdrByte0);
        send_byte(($urandom_range(0, 1) == 0) ? HdrByte2 : 8'h00);
      end
      3: begin
        send_byte(HdrByte0);
        send_byte(HdrByte0);
        send_byte(8'($urandom_range(0, 252)));
      end
      default: ;
    endcase
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      len = 16'($urandom_range(0, 3));
    end else if (sel < 16 && cur_max != 16'hFFFF) begin
      len = 16'($urandom_range(32'(cur_max) + 1, 65535));
    end else begin
      npar = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (sel > 96) npar = $urandom_range(13, 40);
      if (npar + 4 > 32'(cur_max)) npar = 32'(cur_max) - 4;
      len = 16'(npar + 4);
    end
    send_packet(8'($urandom_range(0, 255)), len, 8'($urandom_range(0, 255)),
                ($urandom_range(0, 9) == 0), ($urandom_range(0, 9) == 0),
                ($urandom_range(0, 6) == 0),
                (cur_max <= 16'd600 && $urandom_range(0, 99) < 6) ?
                  $urandom_range(3, 10) : 32'hFFFF_FFFF);
  endtask

  initial begin
    logic [15:0] next_max;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: broken hunt, extra FF before a zero-parameter packet with all-ones
    // ID and error, a length below four, and an over-long length that also carries
    // a bad reserved byte (length status wins).
    send_byte(HdrByte0);
    send_byte(8'h00);
    send_byte(HdrByte0);
    send_packet(8'hFF, 16'd4, 8'hFF, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_packet(8'h00, 16'd3, 8'h00, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_packet(8'hA5, MaxLengthRst + 16'd1, 8'h00, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);

    // Random traffic under several max_length settings: reset value, minimum,
    // maximum, a small random one, then the reset value written explicitly.
    for (int s = 0; s < NumSettings; s++) begin
      if (s != 0) begin
        case (s)
          1:       next_max = MinLength;
          2:       next_max = 16'hFFFF;
          3:       next_max = 16'($urandom_range(5, 64));
          default: next_max = MaxLengthRst;
        endcase
        write_max_len(next_max);
      end
      // one long packet while the limit allows it; pushes param_count past a byte
      if (s == 2) send_packet(8'h3C, 16'd260, 8'h00, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
      while (packet_bytes < (s + 1) * ByteTarget / NumSettings) send_random_traffic();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ssp_pkg.sv
rtl/ssp_parser.sv
rtl/ssp_result_buf.sv
rtl/servo_status_packet_parser_top.sv
verif/servo_status_packet_parser_checker.sv
verif/servo_status_packet_parser_top_tb.sv
